// File: design/tsi_pkg.sv
`default_nettype none
package tsi_pkg;

	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	localparam logic [1:0] ST_INTERP = 2'd0;
	localparam logic [1:0] ST_OLDEST = 2'd1;
	localparam logic [1:0] ST_NEWEST = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [31:0]        tick;
		logic [5:0]         lane;
		logic signed [31:0] sample_value;
		logic [39:0]        render_time;
	} in_item_t;

	typedef struct packed {
		logic [5:0]         out_lane;
		logic signed [31:0] lane_value;
		logic               last;
		logic [1:0]         status;
	} out_item_t;

endpackage
`default_nettype wire

// File: design/tsi_ram.sv
`default_nettype none
module tsi_ram #(
	parameter int WIDTH = 32,
	parameter int WORDS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(WORDS)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(WORDS)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: design/tsi_fifo.sv
`default_nettype none
module tsi_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rdata   = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// File: design/tsi_front.sv
`default_nettype none
module tsi_front #(
	parameter int LANES = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tsi_pkg::in_item_t  in_item,
	output logic                    full,
	input  wire logic               deq,
	output tsi_pkg::in_item_t       deq_item,
	output logic                    deq_empty
);
	import tsi_pkg::*;

	logic     keep;
	in_item_t q_out;

	// drop the unused command and writes to lanes that do not exist
	always_comb begin
		unique case (in_item.cmd)
			CMD_PUSH:  keep = 1'b1;
			CMD_WRITE: keep = ({26'd0, in_item.lane} < 32'(LANES));
			CMD_QUERY: keep = 1'b1;
			default:   keep = 1'b0;
		endcase
	end

	tsi_fifo #(.WIDTH($bits(in_item_t))) u_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && keep),
		.wdata (in_item),
		.full  (full),
		.pop   (deq),
		.rdata (q_out),
		.empty (deq_empty)
	);

	assign deq_item = q_out;

endmodule
`default_nettype wire

// File: design/tsi_back.sv
`default_nettype none
module tsi_back #(
	parameter int DEPTH = 16,
	parameter int LANES = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [63:0]        angle_mask,
	input  wire logic               in_empty,
	input  wire tsi_pkg::in_item_t  in_item,
	output logic                    in_pop,
	input  wire logic               out_full,
	output logic                    out_push,
	output tsi_pkg::out_item_t      out_item
);
	import tsi_pkg::*;

	localparam int SW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int VAW = $clog2(DEPTH * LANES);

	localparam logic signed [33:0] PI_Q      = 34'sd205887;
	localparam logic [34:0]        TWO_PI_Q  = 35'd411775;
	// pi plus a whole number of turns large enough to keep the residue positive
	localparam logic signed [35:0] WRAP_BIAS = 36'sd4295430912;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CLR    = 4'd1;
	localparam logic [3:0] S_TFIRST = 4'd2;
	localparam logic [3:0] S_TNEXT  = 4'd3;
	localparam logic [3:0] S_DIV    = 4'd4;
	localparam logic [3:0] S_LRA    = 4'd5;
	localparam logic [3:0] S_LRB    = 4'd6;
	localparam logic [3:0] S_LD     = 4'd7;
	localparam logic [3:0] S_LWRAP  = 4'd8;
	localparam logic [3:0] S_LMUL   = 4'd9;
	localparam logic [3:0] S_LADD   = 4'd10;
	localparam logic [3:0] S_LOUT   = 4'd11;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		logic [SW-1:0] r;
		r = (s == SW'(DEPTH - 1)) ? '0 : s + 1'b1;
		return r;
	endfunction

	function automatic logic [VAW-1:0] vaddr(input logic [SW-1:0] s, input logic [5:0] l);
		logic [VAW-1:0] a;
		a = VAW'(VAW'(s) * VAW'(LANES)) + VAW'(l);
		return a;
	endfunction

	logic [3:0]         state_q;
	logic [SW-1:0]      newest_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      pair_q;
	logic [SW-1:0]      oldest_q;
	logic [SW-1:0]      sa_q;
	logic [SW-1:0]      sb_q;
	logic [SW-1:0]      slot_a_q;
	logic [SW-1:0]      slot_b_q;
	logic [31:0]        ta_q;
	logic [31:0]        tfirst_q;
	logic [39:0]        rt_q;
	logic [40:0]        rem_q;
	logic [39:0]        span_q;
	logic [4:0]         div_cnt_q;
	logic [16:0]        w_q;
	logic [5:0]         lane_q;
	logic [1:0]         status_q;
	logic               empty_q;
	logic signed [31:0] a_q;
	logic signed [33:0] d_q;
	logic [34:0]        e_q;
	logic [3:0]         wcnt_q;
	logic signed [51:0] p_q;
	logic signed [31:0] res_q;

	logic [SW-1:0]      newest_inc;
	logic [SW+1:0]      old_sum;
	logic [SW-1:0]      oldest;
	logic               t_we;
	logic [SW-1:0]      t_raddr;
	logic [31:0]        t_rdata;
	logic               v_we;
	logic [VAW-1:0]     v_waddr;
	logic [31:0]        v_wdata;
	logic [VAW-1:0]     v_raddr;
	logic [31:0]        v_rdata;
	logic [39:0]        ta_ext;
	logic [39:0]        tb_ext;
	logic               bracket;
	logic               last_pair;
	logic [40:0]        trial;
	logic               div_ge;
	logic signed [33:0] d_n;
	logic [34:0]        wrap_sub;
	logic [34:0]        e_next;
	logic signed [51:0] p_rnd;
	logic signed [36:0] sum;
	logic signed [31:0] sat;
	logic               out_last;

	assign newest_inc = slot_inc(newest_q);
	assign old_sum    = (SW+2)'(newest_q) + (SW+2)'(DEPTH + 1) - (SW+2)'(count_q);
	assign oldest     = (old_sum >= (SW+2)'(DEPTH)) ? SW'(old_sum - (SW+2)'(DEPTH))
	                                                : SW'(old_sum);

	assign in_pop = (state_q == S_IDLE) && !in_empty;
	assign t_we   = in_pop && (in_item.cmd == CMD_PUSH);

	always_comb begin
		unique case (state_q)
			S_IDLE:   t_raddr = oldest;
			S_TFIRST: t_raddr = slot_inc(sa_q);
			S_TNEXT:  t_raddr = slot_inc(sb_q);
			default:  t_raddr = '0;
		endcase
	end

	always_comb begin
		if (state_q == S_CLR) begin
			v_we    = 1'b1;
			v_waddr = vaddr(newest_q, lane_q);
			v_wdata = '0;
		end else begin
			v_we    = in_pop && (in_item.cmd == CMD_WRITE) && (count_q != '0);
			v_waddr = vaddr(newest_q, in_item.lane);
			v_wdata = in_item.sample_value;
		end
		v_raddr = (state_q == S_LRB) ? vaddr(slot_b_q, lane_q) : vaddr(slot_a_q, lane_q);
	end

	tsi_ram #(.WIDTH(32), .WORDS(DEPTH)) u_ticks (
		.clk  (clk),
		.we   (t_we),
		.waddr(newest_inc),
		.wdata(in_item.tick),
		.raddr(t_raddr),
		.rdata(t_rdata)
	);

	tsi_ram #(.WIDTH(32), .WORDS(DEPTH * LANES)) u_values (
		.clk  (clk),
		.we   (v_we),
		.waddr(v_waddr),
		.wdata(v_wdata),
		.raddr(v_raddr),
		.rdata(v_rdata)
	);

	assign ta_ext    = {ta_q, 8'd0};
	assign tb_ext    = {t_rdata, 8'd0};
	assign bracket   = (ta_ext <= rt_q) && (tb_ext >= rt_q);
	assign last_pair = ((pair_q + CW'(2)) == count_q);

	assign trial  = (div_cnt_q == 5'd16) ? rem_q : {rem_q[39:0], 1'b0};
	assign div_ge = (trial >= {1'b0, span_q});

	assign d_n      = 34'(signed'(v_rdata)) - 34'(a_q);
	assign wrap_sub = TWO_PI_Q << wcnt_q;
	assign e_next   = (e_q >= wrap_sub) ? e_q - wrap_sub : e_q;

	// round half up, then add the base value and clamp
	assign p_rnd = (p_q + 52'sd32768) >>> 16;
	assign sum   = 37'(a_q) + p_rnd[36:0];
	always_comb begin
		if (sum > 37'sd2147483647) begin
			sat = 32'sh7fffffff;
		end else if (sum < -37'sd2147483648) begin
			sat = 32'sh80000000;
		end else begin
			sat = sum[31:0];
		end
	end

	assign out_last          = empty_q || (lane_q == 6'(LANES - 1));
	assign out_push          = (state_q == S_LOUT);
	assign out_item.out_lane   = lane_q;
	assign out_item.lane_value = res_q;
	assign out_item.last       = out_last;
	assign out_item.status     = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			newest_q  <= SW'(DEPTH - 1);
			count_q   <= '0;
			empty_q   <= 1'b0;
			lane_q    <= '0;
			pair_q    <= '0;
			div_cnt_q <= '0;
			wcnt_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!in_empty) begin
						unique case (in_item.cmd)
							CMD_PUSH: begin
								newest_q <= newest_inc;
								if (count_q != CW'(DEPTH)) begin
									count_q <= count_q + 1'b1;
								end
								lane_q  <= '0;
								state_q <= S_CLR;
							end
							CMD_QUERY: begin
								rt_q    <= in_item.render_time;
								lane_q  <= '0;
								if (count_q == '0) begin
									res_q    <= '0;
									status_q <= ST_EMPTY;
									empty_q  <= 1'b1;
									state_q  <= S_LOUT;
								end else if (count_q == CW'(1)) begin
									slot_a_q <= newest_q;
									status_q <= ST_NEWEST;
									state_q  <= S_LRA;
								end else begin
									oldest_q <= oldest;
									sa_q     <= oldest;
									pair_q   <= '0;
									state_q  <= S_TFIRST;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_CLR: begin
					lane_q <= lane_q + 6'd1;
					if (lane_q == 6'(LANES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_TFIRST: begin
					ta_q     <= t_rdata;
					tfirst_q <= t_rdata;
					sb_q     <= slot_inc(sa_q);
					state_q  <= S_TNEXT;
				end
				S_TNEXT: begin
					if (bracket) begin
						slot_a_q  <= sa_q;
						slot_b_q  <= sb_q;
						status_q  <= ST_INTERP;
						rem_q     <= {1'b0, rt_q - ta_ext};
						span_q    <= tb_ext - ta_ext;
						w_q       <= '0;
						div_cnt_q <= 5'd16;
						lane_q    <= '0;
						state_q   <= (tb_ext == ta_ext) ? S_LRA : S_DIV;
					end else if (last_pair) begin
						lane_q <= '0;
						if (rt_q < {tfirst_q, 8'd0}) begin
							slot_a_q <= oldest_q;
							status_q <= ST_OLDEST;
						end else begin
							slot_a_q <= newest_q;
							status_q <= ST_NEWEST;
						end
						state_q <= S_LRA;
					end else begin
						sa_q   <= sb_q;
						ta_q   <= t_rdata;
						sb_q   <= slot_inc(sb_q);
						pair_q <= pair_q + 1'b1;
					end
				end
				S_DIV: begin
					rem_q <= div_ge ? trial - {1'b0, span_q} : trial;
					w_q   <= {w_q[15:0], div_ge};
					if (div_cnt_q == 5'd0) begin
						state_q <= S_LRA;
					end else begin
						div_cnt_q <= div_cnt_q - 5'd1;
					end
				end
				S_LRA: begin
					state_q <= S_LRB;
				end
				S_LRB: begin
					a_q <= v_rdata;
					if (status_q != ST_INTERP) begin
						res_q   <= v_rdata;
						state_q <= S_LOUT;
					end else begin
						state_q <= S_LD;
					end
				end
				S_LD: begin
					if (angle_mask[lane_q]) begin
						e_q     <= 35'(36'(d_n) + WRAP_BIAS);
						wcnt_q  <= 4'd14;
						state_q <= S_LWRAP;
					end else begin
						d_q     <= d_n;
						state_q <= S_LMUL;
					end
				end
				S_LWRAP: begin
					e_q <= e_next;
					if (wcnt_q == 4'd0) begin
						d_q     <= signed'({1'b0, e_next[32:0]}) - PI_Q;
						state_q <= S_LMUL;
					end else begin
						wcnt_q <= wcnt_q - 4'd1;
					end
				end
				S_LMUL: begin
					p_q     <= 52'(d_q) * 52'(signed'({1'b0, w_q}));
					state_q <= S_LADD;
				end
				S_LADD: begin
					res_q   <= sat;
					state_q <= S_LOUT;
				end
				S_LOUT: begin
					if (!out_full) begin
						if (out_last) begin
							empty_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							lane_q  <= lane_q + 6'd1;
							state_q <= S_LRA;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: design/timestamped_snapshot_interpolator_unit.sv
`default_nettype none
// Channel   Signals                 Beat taken when
// input     push, full, in_item     push high and full low
// result    pop, empty, out_item    pop high and empty low
// config    cfg_we, cfg_wdata       cfg_we high
//
// Push: writes the tick, then clears one lane per cycle. Write: stores one lane value
// in the newest snapshot. Query: a search over pairs of ticks, the weight divider,
// then a blend per lane (angle lanes also go through the wrap subtractor), or a copy
// per lane when one snapshot is copied; an empty ring answers with one beat.
// Lane values come from a single-read-port memory, two reads per blended lane.
// Reset empties the ring; no clearing pass. Either side may stall; two-beat queues
// sit on both sides of the engine.
module timestamped_snapshot_interpolator_unit #(
	parameter int DEPTH = 16,
	parameter int LANES = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire tsi_pkg::in_item_t  in_item,
	output logic                    empty,
	input  wire logic               pop,
	output tsi_pkg::out_item_t      out_item,
	input  wire logic               cfg_we,
	input  wire logic [63:0]        cfg_wdata
);
	import tsi_pkg::*;

	logic [63:0] angle_mask_q;
	logic        q_pop;
	logic        q_empty;
	in_item_t    q_item;
	logic        r_full;
	logic        r_push;
	out_item_t   r_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_mask_q <= '0;
		end else if (cfg_we) begin
			angle_mask_q <= cfg_wdata;
		end
	end

	tsi_front #(.LANES(LANES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_item  (in_item),
		.full     (full),
		.deq      (q_pop),
		.deq_item (q_item),
		.deq_empty(q_empty)
	);

	tsi_back #(.DEPTH(DEPTH), .LANES(LANES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.angle_mask(angle_mask_q),
		.in_empty  (q_empty),
		.in_item   (q_item),
		.in_pop    (q_pop),
		.out_full  (r_full),
		.out_push  (r_push),
		.out_item  (r_item)
	);

	tsi_fifo #(.WIDTH($bits(out_item_t))) u_res (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (r_push),
		.wdata (r_item),
		.full  (r_full),
		.pop   (pop),
		.rdata (out_item),
		.empty (empty)
	);

endmodule
`default_nettype wire

// File: test/tb_top.sv
`default_nettype none
module tb_top;
	import tsi_pkg::*;

	localparam int SLOTS     = 16;
	localparam int NLANES    = 32;
	localparam longint PI_Q  = 205887;
	localparam longint TPI_Q = 411775;
	localparam int MAX_CYC   = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	in_item_t    in_item = '0;
	logic        empty;
	logic        pop = 1'b0;
	out_item_t   out_item;
	logic        cfg_we = 1'b0;
	logic [63:0] cfg_wdata = '0;

	timestamped_snapshot_interpolator_unit #(.DEPTH(SLOTS), .LANES(NLANES)) i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item), .cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// snapshot ring as the block should hold it
	logic [31:0]        ring_tick [SLOTS];
	logic signed [31:0] ring_val  [SLOTS][NLANES];
	int                 newest = SLOTS - 1;
	int                 filled = 0;
	logic [63:0]        angle_mask = '0;

	in_item_t  pending_items[$];
	out_item_t lane_results[$];
	int        errors = 0;
	int        beats_in = 0;
	int        beats_out = 0;
	int        queries = 0;
	int        cycles = 0;

	function automatic logic signed [31:0] blend(int sa, int sb, int k, longint w);
		longint a, b, d, r;
		a = ring_val[sa][k];
		b = ring_val[sb][k];
		d = b - a;
		if (angle_mask[k]) begin
			if (d > PI_Q)
				d -= ((d - PI_Q + TPI_Q - 1) / TPI_Q) * TPI_Q;
			else if (d < -PI_Q)
				d += ((-PI_Q - d + TPI_Q - 1) / TPI_Q) * TPI_Q;
		end
		r = a + ((d * w + 32768) >>> 16);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	task automatic emit_lanes(int sa, int sb, longint w, logic [1:0] st);
		out_item_t o;
		for (int k = 0; k < NLANES; k++) begin
			o.out_lane   = k[5:0];
			o.lane_value = (st == ST_INTERP) ? blend(sa, sb, k, w) : ring_val[sa][k];
			o.last       = (k == NLANES - 1);
			o.status     = st;
			lane_results.push_back(o);
		end
	endtask

	task automatic predict_item(in_item_t it);
		int oldest, sa, sb;
		logic [63:0] ta, tb, rt, w;
		out_item_t o;
		bit hit;
		hit = 0;
		case (it.cmd)
			CMD_PUSH: begin
				newest = (newest + 1) % SLOTS;
				ring_tick[newest] = it.tick;
				for (int k = 0; k < NLANES; k++) ring_val[newest][k] = '0;
				if (filled < SLOTS) filled++;
			end
			CMD_WRITE: begin
				if (filled != 0 && it.lane < NLANES) ring_val[newest][it.lane] = it.sample_value;
			end
			CMD_QUERY: begin
				queries++;
				rt = {24'b0, it.render_time};
				if (filled == 0) begin
					o.out_lane = '0; o.lane_value = '0; o.last = 1'b1; o.status = ST_EMPTY;
					lane_results.push_back(o);
				end else if (filled == 1) begin
					emit_lanes(newest, newest, 0, ST_NEWEST);
				end else begin
					oldest = (newest + SLOTS + 1 - filled) % SLOTS;
					for (int i = 0; i + 1 < filled && !hit; i++) begin
						sa = (oldest + i) % SLOTS;
						sb = (sa + 1) % SLOTS;
						ta = {24'b0, ring_tick[sa], 8'b0};
						tb = {24'b0, ring_tick[sb], 8'b0};
						if (ta <= rt && tb >= rt) begin
							hit = 1;
							w = 0;
							if (tb != ta) begin
								w = ((rt - ta) << 16) / (tb - ta);
								if (w > 65536) w = 65536;
							end
							emit_lanes(sa, sb, longint'(w), ST_INTERP);
						end
					end
					if (!hit) begin
						if (rt < {24'b0, ring_tick[oldest], 8'b0})
							emit_lanes(oldest, oldest, 0, ST_OLDEST);
						else
							emit_lanes(newest, newest, 0, ST_NEWEST);
					end
				end
			end
			default: ;
		endcase
	endtask

	// sender: bursts and gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		cycles++;
		if (push && !full) begin
			predict_item(pending_items.pop_front());
			beats_in++;
		end
		if (pop && !empty) begin
			beats_out++;
			if (lane_results.size() == 0) begin
				$error("result beat with nothing expected: lane %0d", out_item.out_lane);
				errors++;
			end else begin
				out_item_t e;
				e = lane_results.pop_front();
				if (out_item.out_lane !== e.out_lane) begin
					$error("out_lane expected %0d got %0d", e.out_lane, out_item.out_lane);
					errors++;
				end
				if (out_item.lane_value !== e.lane_value) begin
					$error("lane_value expected %0d got %0d", e.lane_value, out_item.lane_value);
					errors++;
				end
				if (out_item.last !== e.last) begin
					$error("last expected %0b got %0b", e.last, out_item.last);
					errors++;
				end
				if (out_item.status !== e.status) begin
					$error("status expected %0d got %0d", e.status, out_item.status);
					errors++;
				end
			end
		end
		if (cycles > MAX_CYC) begin
			$display("timeout after %0d cycles", cycles);
			$display("** timestamped_snapshot_interpolator_unit: FAILED **");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (gap_left > 0) begin
			gap_left--;
			push <= 1'b0;
		end else if (pending_items.size() != 0) begin
			push    <= 1'b1;
			in_item <= pending_items[0];
			if (burst_left > 0) burst_left--;
			else begin
				burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 12);
				gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
			end
		end else
			push <= 1'b0;
	end

	// receiver: rotate a stall pattern, reshuffled now and then
	logic [15:0] pop_pat = 16'hFFFF;
	always @(negedge clk) begin
		if (cycles % 300 == 0)
			pop_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
		pop_pat = {pop_pat[14:0], pop_pat[15]};
		pop <= pop_pat[0];
	end

	logic [31:0] gen_tick[$];

	task automatic add(logic [1:0] c, logic [31:0] t, logic [5:0] l, logic [31:0] v,
			logic [39:0] r);
		in_item_t it;
		it.cmd = c; it.tick = t; it.lane = l; it.sample_value = v; it.render_time = r;
		pending_items.push_back(it);
		if (c == CMD_PUSH) begin
			gen_tick.push_back(t);
			if (gen_tick.size() > SLOTS) void'(gen_tick.pop_front());
		end
	endtask

	task automatic drain_and_write(logic [63:0] mask);
		wait (pending_items.size() == 0 && lane_results.size() == 0);
		@(negedge clk);
		wait (lane_results.size() == 0);
		repeat (200) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mask;
		@(negedge clk);
		cfg_we <= 1'b0;
		angle_mask = mask;
	endtask

	task automatic random_seq(int n);
		int made, nw;
		logic [31:0] t, lo, hi;
		made = 0;
		while (made < n) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: stray command or wild fields
				add(2'($urandom_range(1, 3)), $urandom, 6'($urandom), $urandom,
					{8'($urandom), 32'($urandom)});
				made++;
				continue;
			end
			if ($urandom_range(0, 7) == 0 || gen_tick.size() == 0) t = $urandom;
			else t = gen_tick[$] + $urandom_range(0, 40);
			add(CMD_PUSH, t, 6'($urandom), $urandom, 40'($urandom));
			nw = $urandom_range(0, 6);
			for (int i = 0; i < nw; i++)
				add(CMD_WRITE, $urandom, 6'($urandom_range(0, 40)), $urandom, 40'($urandom));
			lo = gen_tick[0];
			hi = gen_tick[$];
			if (lo > hi) begin lo = hi; hi = gen_tick[0]; end
			add(CMD_QUERY, $urandom, 6'($urandom), $urandom,
				{lo, 8'b0} + 40'($urandom_range(0, 1 + (hi - lo + 2) * 256)) - 40'd256);
			made += nw + 2;
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		drain_and_write(64'h0);
		// empty ring, write into empty ring, one snapshot
		add(CMD_QUERY, 0, 0, 0, 40'hFF_FFFF_FFFF);
		add(CMD_WRITE, 0, 0, 32'h1234_5678, 0);
		add(CMD_PUSH, 10, 0, 0, 0);
		add(CMD_WRITE, 0, 0, 32'h7FFF_FFFF, 0);
		add(CMD_WRITE, 0, 31, 32'h8000_0000, 0);
		add(CMD_WRITE, 0, 63, 32'hFFFF_FFFF, 0);
		add(CMD_WRITE, 0, 32, 32'h5555_5555, 0);
		add(CMD_QUERY, 0, 0, 0, 40'd2560);
		add(CMD_PUSH, 20, 0, 0, 0);
		add(CMD_WRITE, 0, 0, 32'h8000_0000, 0);
		add(CMD_WRITE, 0, 31, 32'h7FFF_FFFF, 0);
		add(CMD_QUERY, 0, 0, 0, 40'd100);         // before oldest
		add(CMD_QUERY, 0, 0, 0, 40'd3840);        // midpoint
		add(CMD_QUERY, 0, 0, 0, 40'd9000);        // after newest
		add(CMD_PUSH, 20, 0, 0, 0);               // equal ticks, zero span
		add(CMD_QUERY, 0, 0, 0, 40'd5120);
		add(CMD_NONE, '1, '1, '1, '1);
		add(CMD_PUSH, 32'hFFFF_FFFF, 0, 0, 0);
		add(CMD_WRITE, 0, 5, 32'h0003_0000, 0);
		add(CMD_QUERY, 0, 0, 0, 40'hFF_FFFF_FFFF);
		add(CMD_QUERY, 0, 0, 0, 40'hFF_FFFF_FF00);
		random_seq(30);

		drain_and_write(64'hFFFF_FFFF_FFFF_FFFF);
		add(CMD_QUERY, 0, 0, 0, 40'hFF_FFFF_FF80);
		random_seq(35);

		drain_and_write({$urandom, $urandom});
		random_seq(35);

		drain_and_write(64'hAAAA_AAAA_5555_5555);
		random_seq(20);

		wait (pending_items.size() == 0 && lane_results.size() == 0);
		repeat (800) @(posedge clk);
		$display("covered %0d input beats, %0d queries, %0d result beats, four angle masks",
			beats_in, queries, beats_out);
		if (lane_results.size() != 0) begin
			$error("%0d results never arrived", lane_results.size());
			errors++;
		end
		if (errors == 0)
			$display("** timestamped_snapshot_interpolator_unit: PASSED **");
		else
			$display("** timestamped_snapshot_interpolator_unit: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
